// ===== rtl/omni_wheel_move_controller_defines.svh =====
// Assertion macros for the move controller.
// Each expects clk and arst_n in scope.
`ifndef OMNI_WHEEL_MOVE_CONTROLLER_DEFINES_SVH
`define OMNI_WHEEL_MOVE_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define OWMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owmc assertion failed");

`define OWMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owmc assertion failed");

`else

`define OWMC_ASSERT_IMP(lbl, ante, cons)

`define OWMC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/owmc_pkg.sv =====
`timescale 1ns / 1ps
package owmc_pkg;

	localparam int VEL_W     = 16;
	localparam int ENC_W     = 32;
	localparam int SCALE_W   = 8;
	localparam int TOL_W     = 16;
	localparam int DUTY_W    = 8;
	localparam int DMAX_W    = 16;
	localparam int DUTY_DEF  = 255;
	localparam int KIN_W     = 27;
	localparam int NUM_W     = 40;
	localparam int MAG_W     = 38;
	localparam int GAIN_W    = 23;
	localparam int PROD_T_W  = MAG_W + GAIN_W;
	localparam int PROD_D_W  = MAG_W + DMAX_W;
	localparam int SP_W      = PROD_T_W + SCALE_W;
	localparam int FRAC_W    = 40;
	localparam int TGT_W     = SP_W - FRAC_W + 1;
	localparam int CMP_W     = ENC_W + 1;

	localparam logic [GAIN_W-1:0] GAIN_Q16 = GAIN_W'(5903988);
	localparam logic signed [NUM_W-1:0] ROOT3_500_Q12 = NUM_W'(3547240);

	// stage map
	localparam int ST_KIN  = 4;
	localparam int ST_DIV0 = 5;
	localparam int ST_TGT  = 7;
	localparam int ST_LAST = 12;
	localparam int NSTG    = 13;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_TOL   = 1'b1;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] rot_w;
		logic signed [ENC_W-1:0] enc_count_1;
		logic signed [ENC_W-1:0] enc_count_2;
		logic signed [ENC_W-1:0] enc_count_3;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_1;
		logic [DUTY_W-1:0] duty_2;
		logic [DUTY_W-1:0] duty_3;
		logic              reverse_1;
		logic              reverse_2;
		logic              reverse_3;
		logic              move_done;
	} res_t;

	typedef struct packed {
		logic [NSTG:1] vld;
		logic [NSTG:1] en;
	} ctl_t;

	typedef struct packed {
		logic [MAG_W-1:0]              amax;
		logic [2:0][PROD_T_W-1:0]      pt;
		logic [2:0][PROD_D_W-1:0]      pd;
		logic [2:0][ENC_W-1:0]         enc;
		logic [2:0]                    rev;
	} kin_t;

	typedef struct packed {
		logic [2:0][DUTY_W-1:0] q;
		logic [2:0]             sat;
		logic                   zero;
	} div_t;

	typedef struct packed {
		logic [2:0] drv;
		logic [2:0] rev;
	} tgt_t;

endpackage

// ===== rtl/owmc_kin.sv =====
`timescale 1ns / 1ps
`include "omni_wheel_move_controller_defines.svh"
module owmc_kin
	import owmc_pkg::*;
#(
	parameter int DUTY_MAX = DUTY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  cmd_t cmd,
	output kin_t kin
);

	logic signed [KIN_W-1:0] a0_s1, ab_s1;
	logic signed [NUM_W-1:0] ky_s1;
	logic [2:0][ENC_W-1:0]   enc_s1, enc_s2, enc_s3;
	logic signed [NUM_W-1:0] num_s2 [3];
	logic [2:0][MAG_W-1:0]   mag_s3;
	logic [2:0]              rev_s3;
	logic [MAG_W-1:0]        amax_s4;
	logic [2:0][PROD_T_W-1:0] pt_s4;
	logic [2:0][PROD_D_W-1:0] pd_s4;
	logic [2:0][ENC_W-1:0]   enc_s4;
	logic [2:0]              rev_s4;

	logic signed [KIN_W-1:0] w27, x27;
	logic signed [ENC_W-1:0] enc_in [3];
	logic [MAG_W-1:0]        m01;

	always_comb begin
		w27 = KIN_W'(cmd.rot_w);
		x27 = KIN_W'(cmd.vel_x);
		enc_in[0] = cmd.enc_count_1;
		enc_in[1] = cmd.enc_count_2;
		enc_in[2] = cmd.enc_count_3;
		m01 = (mag_s3[1] > mag_s3[0]) ? mag_s3[1] : mag_s3[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			a0_s1 <= KIN_W'(175) * w27 - KIN_W'(1000) * x27;
			ab_s1 <= KIN_W'(175) * w27 + KIN_W'(500) * x27;
			ky_s1 <= ROOT3_500_Q12 * NUM_W'(cmd.vel_y);
			for (int i = 0; i < 3; i++) begin
				enc_s1[i] <= enc_in[i][ENC_W-1] ? ENC_W'(-enc_in[i]) : ENC_W'(enc_in[i]);
			end
		end
		if (ctl.en[2]) begin
			num_s2[0] <= NUM_W'(a0_s1) <<< 12;
			num_s2[1] <= (NUM_W'(ab_s1) <<< 12) - ky_s1;
			num_s2[2] <= (NUM_W'(ab_s1) <<< 12) + ky_s1;
			enc_s2    <= enc_s1;
		end
		if (ctl.en[3]) begin
			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= num_s2[i][NUM_W-1] ? MAG_W'(-num_s2[i]) : MAG_W'(num_s2[i]);
				rev_s3[i] <= num_s2[i][NUM_W-1];
			end
			enc_s3 <= enc_s2;
		end
		if (ctl.en[ST_KIN]) begin
			amax_s4 <= (mag_s3[2] > m01) ? mag_s3[2] : m01;
			for (int i = 0; i < 3; i++) begin
				pt_s4[i] <= PROD_T_W'(mag_s3[i]) * PROD_T_W'(GAIN_Q16);
				pd_s4[i] <= PROD_D_W'(mag_s3[i]) * PROD_D_W'(DUTY_MAX);
			end
			enc_s4 <= enc_s3;
			rev_s4 <= rev_s3;
		end
	end

	always_comb begin
		kin.amax = amax_s4;
		kin.pt   = pt_s4;
		kin.pd   = pd_s4;
		kin.enc  = enc_s4;
		kin.rev  = rev_s4;
	end

	`OWMC_ASSERT_IMP(a_zero_max_zero_prod, ctl.vld[ST_KIN] && amax_s4 == '0, pd_s4 == '0)

endmodule

// ===== rtl/owmc_div.sv =====
`timescale 1ns / 1ps
`include "omni_wheel_move_controller_defines.svh"
module owmc_div
	import owmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  kin_t kin,
	output div_t div
);

	// restoring divide, one quotient bit per stage, MSB first
	logic [2:0][PROD_D_W-1:0] rem_s  [ST_DIV0:ST_LAST];
	logic [2:0][DUTY_W-1:0]   q_s    [ST_DIV0:ST_LAST];
	logic [2:0]               sat_s  [ST_DIV0:ST_LAST];
	logic                     zero_s [ST_DIV0:ST_LAST];
	logic [MAG_W-1:0]         m_s    [ST_DIV0:ST_LAST-1];

	logic [PROD_D_W-1:0] dv0, lim0;
	logic [2:0]          ge0;

	always_comb begin
		dv0  = PROD_D_W'(kin.amax) << (ST_LAST - ST_DIV0);
		lim0 = PROD_D_W'(kin.amax) << DUTY_W;
		for (int i = 0; i < 3; i++) begin
			ge0[i] = kin.pd[i] >= dv0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_DIV0]) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[ST_DIV0][i] <= ge0[i] ? kin.pd[i] - dv0 : kin.pd[i];
				q_s[ST_DIV0][i]   <= ge0[i] ? DUTY_W'(1 << (ST_LAST - ST_DIV0)) : '0;
				sat_s[ST_DIV0][i] <= kin.pd[i] >= lim0;
			end
			zero_s[ST_DIV0] <= kin.amax == '0;
			m_s[ST_DIV0]    <= kin.amax;
		end
	end

	for (genvar st = ST_DIV0 + 1; st <= ST_LAST; st++) begin : g_step
		logic [PROD_D_W-1:0] dv;
		logic [2:0]          ge;

		always_comb begin
			dv = PROD_D_W'(m_s[st-1]) << (ST_LAST - st);
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[st-1][i] >= dv;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en[st]) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[st][i] <= ge[i] ? rem_s[st-1][i] - dv : rem_s[st-1][i];
					q_s[st][i]   <= q_s[st-1][i] | (ge[i] ? DUTY_W'(1 << (ST_LAST - st)) : '0);
				end
				sat_s[st]  <= sat_s[st-1];
				zero_s[st] <= zero_s[st-1];
			end
		end

		if (st < ST_LAST) begin : g_m
			always_ff @(posedge clk) begin
				if (ctl.en[st]) begin
					m_s[st] <= m_s[st-1];
				end
			end
		end
	end

	always_comb begin
		div.q    = q_s[ST_LAST];
		div.sat  = sat_s[ST_LAST];
		div.zero = zero_s[ST_LAST];
	end

	// an all-zero divisor means every dividend is zero, which compares as saturated
	`OWMC_ASSERT_IMP(a_zero_implies_sat, ctl.vld[ST_LAST] && zero_s[ST_LAST], &sat_s[ST_LAST])

endmodule

// ===== rtl/owmc_tgt.sv =====
`timescale 1ns / 1ps
module owmc_tgt
	import owmc_pkg::*;
(
	input  logic                     clk,
	input  ctl_t                     ctl,
	input  kin_t                     kin,
	input  logic [SCALE_W-1:0]       scale,
	input  logic signed [TOL_W-1:0]  tol,
	output tgt_t                     tgt
);

	logic [2:0][SP_W-1:0]  sp_s5;
	logic [2:0][ENC_W-1:0] enc_s5, enc_s6;
	logic [2:0][TGT_W-1:0] t_s6;
	logic [2:0]            rev_s [ST_DIV0:ST_LAST];
	logic [2:0]            drv_s [ST_TGT:ST_LAST];

	logic signed [CMP_W-1:0] lim [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lim[i] = $signed({{(CMP_W-TGT_W){1'b0}}, t_s6[i]}) + CMP_W'(tol);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_DIV0]) begin
			for (int i = 0; i < 3; i++) begin
				sp_s5[i] <= SP_W'(scale) * SP_W'(kin.pt[i]);
			end
			enc_s5         <= kin.enc;
			rev_s[ST_DIV0] <= kin.rev;
		end
		if (ctl.en[ST_DIV0+1]) begin
			// round the fractional travel target up
			for (int i = 0; i < 3; i++) begin
				t_s6[i] <= TGT_W'(sp_s5[i][SP_W-1:FRAC_W]) + TGT_W'(|sp_s5[i][FRAC_W-1:0]);
			end
			enc_s6 <= enc_s5;
		end
		if (ctl.en[ST_TGT]) begin
			for (int i = 0; i < 3; i++) begin
				drv_s[ST_TGT][i] <= $signed({1'b0, enc_s6[i]}) < lim[i];
			end
		end
	end

	for (genvar st = ST_DIV0 + 1; st <= ST_LAST; st++) begin : g_rev
		always_ff @(posedge clk) begin
			if (ctl.en[st]) begin
				rev_s[st] <= rev_s[st-1];
			end
		end
	end

	for (genvar st = ST_TGT + 1; st <= ST_LAST; st++) begin : g_drv
		always_ff @(posedge clk) begin
			if (ctl.en[st]) begin
				drv_s[st] <= drv_s[st-1];
			end
		end
	end

	always_comb begin
		tgt.drv = drv_s[ST_LAST];
		tgt.rev = rev_s[ST_LAST];
	end

endmodule

// ===== rtl/omni_wheel_move_controller.sv =====
// channel   dir  handshake             payload
// cmd       in   cmd_valid/cmd_stall   cmd_t: velocities, encoder counts
// res       out  res_valid/res_stall   res_t: duties, directions, done
// apb       in   psel/penable/pwrite   distance_scale, count_tolerance
//
// The pipe has 13 stages; it takes one item per cycle while the result is not stalled.
// Eight of the stages are the restoring duty divider, one quotient bit each.
// A stalled result holds the last stage; empty stages upstream keep filling,
// and input stalls only once every stage holds an item.
// Reset clears the valid bits and sets scale 1, tolerance 0.
`timescale 1ns / 1ps
`include "omni_wheel_move_controller_defines.svh"
module omni_wheel_move_controller
	import owmc_pkg::*;
#(
	parameter int DUTY_MAX = DUTY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [SCALE_W-1:0]      scale_q;
	logic signed [TOL_W-1:0] tol_q;
	logic [NSTG:1]           vld_q;
	ctl_t                    ctl;
	kin_t                    kin;
	div_t                    div;
	tgt_t                    tgt;
	res_t                    res_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			tol_q   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				REG_TOL:   tol_q   <= pwdata[TOL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCALE: prdata = DATA_W'(scale_q);
			REG_TOL:   prdata = DATA_W'(tol_q);
		endcase
	end

	always_comb begin
		ctl.vld     = vld_q;
		ctl.en[NSTG] = !vld_q[NSTG] || !res_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ctl.en[k] = !vld_q[k] || ctl.en[k+1];
		end
	end

	assign cmd_stall = !ctl.en[1];
	assign res_valid = vld_q[NSTG];
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[1]) begin
				vld_q[1] <= cmd_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ctl.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	owmc_kin #(
		.DUTY_MAX(DUTY_MAX)
	) u_kin (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cmd   (cmd),
		.kin   (kin)
	);

	owmc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.kin   (kin),
		.div   (div)
	);

	owmc_tgt u_tgt (
		.clk  (clk),
		.ctl  (ctl),
		.kin  (kin),
		.scale(scale_q),
		.tol  (tol_q),
		.tgt  (tgt)
	);

	logic [2:0][DUTY_W-1:0] duty;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (tgt.drv[i] && !div.zero) begin
				duty[i] = div.sat[i] ? '1 : div.q[i];
			end else begin
				duty[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[NSTG]) begin
			res_q.duty_1    <= duty[0];
			res_q.duty_2    <= duty[1];
			res_q.duty_3    <= duty[2];
			res_q.reverse_1 <= tgt.rev[0];
			res_q.reverse_2 <= tgt.rev[1];
			res_q.reverse_3 <= tgt.rev[2];
			res_q.move_done <= ~|tgt.drv;
		end
	end

	`OWMC_ASSERT_IMP(a_done_no_duty, res_valid && res.move_done, res.duty_1 == '0 && res.duty_2 == '0 && res.duty_3 == '0)
	`OWMC_ASSERT_NXT(a_accept_enters, cmd_valid && !cmd_stall, vld_q[1])
	`OWMC_ASSERT_NXT(a_drain_leaves, res_valid && !res_stall && !vld_q[NSTG-1], !res_valid)

endmodule

// ===== dv/omni_wheel_move_controller_checker.sv =====
`timescale 1ns / 1ps
module omni_wheel_move_controller_checker
	import owmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  cmd_t              cmd,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                errors,
	output int                pending
);
	localparam logic [ADDR_W-1:0] ADDR_SCALE = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_TOL   = ADDR_W'(4);

	logic [7:0]         scale;
	logic signed [15:0] tol;
	res_t               wheel_q[$];

	assign pending = wheel_q.size();

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic res_t wheel_cmds(input cmd_t c);
		logic signed [63:0] x, y, w, base, ky, t;
		logic signed [63:0] n[3];
		logic [63:0] a[3];
		logic [63:0] amax, p, q, r, sr, u, e;
		logic [63:0] msk;
		logic [7:0] d[3];
		logic drv;
		res_t o;
		x = c.vel_x;
		y = c.vel_y;
		w = c.rot_w;
		msk = (64'd1 << 40) - 1;
		base = 4096 * (175 * w + 500 * x);
		ky = 64'sd3547240 * y;
		n[0] = 4096 * (175 * w - 1000 * x);
		n[1] = base - ky;
		n[2] = base + ky;
		amax = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = mag(n[i]);
			if (a[i] > amax) amax = a[i];
		end
		o.move_done = 1'b1;
		for (int i = 0; i < 3; i++) begin
			e = mag(i == 0 ? c.enc_count_1 : i == 1 ? c.enc_count_2 : c.enc_count_3);
			p = a[i] * 64'd5903988;
			q = p >> 40;
			r = p & msk;
			sr = r * scale;
			u = q * scale + (sr >> 40) + ((sr & msk) != 0);
			if (u > 64'h7fffffff) u = 64'h7fffffff;
			t = $signed(u) + tol;
			if (t > 64'sh7fffffff) t = 64'sh7fffffff;
			drv = $signed(e) < t;
			d[i] = 0;
			if (drv && amax != 0) begin
				u = a[i] * 255 / amax;
				d[i] = u > 255 ? 8'd255 : u[7:0];
			end
			if (drv) o.move_done = 1'b0;
		end
		o.duty_1 = d[0];
		o.duty_2 = d[1];
		o.duty_3 = d[2];
		o.reverse_1 = n[0] < 0;
		o.reverse_2 = n[1] < 0;
		o.reverse_3 = n[2] < 0;
		return o;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			scale <= 8'd1;
			tol <= '0;
			errors <= 0;
			wheel_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_SCALE) scale <= pwdata[7:0];
				else if (paddr == ADDR_TOL) tol <= pwdata[15:0];
			end
			if (cmd_valid && !cmd_stall) wheel_q.push_back(wheel_cmds(cmd));
			if (res_valid && !res_stall) begin
				if (wheel_q.size() == 0) begin
					report("result with none expected", 0, 0);
				end else begin
					e = wheel_q.pop_front();
					if (res.duty_1 != e.duty_1) report("duty_1", res.duty_1, e.duty_1);
					if (res.duty_2 != e.duty_2) report("duty_2", res.duty_2, e.duty_2);
					if (res.duty_3 != e.duty_3) report("duty_3", res.duty_3, e.duty_3);
					if (res.reverse_1 != e.reverse_1)
						report("reverse_1", res.reverse_1, e.reverse_1);
					if (res.reverse_2 != e.reverse_2)
						report("reverse_2", res.reverse_2, e.reverse_2);
					if (res.reverse_3 != e.reverse_3)
						report("reverse_3", res.reverse_3, e.reverse_3);
					if (res.move_done != e.move_done)
						report("move_done", res.move_done, e.move_done);
				end
			end
		end
	end
endmodule

// ===== dv/omni_wheel_move_controller_test.sv =====
`timescale 1ns / 1ps
module omni_wheel_move_controller_test;
	import owmc_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cmd_t              cmd = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                idle;

	always #10 clk = ~clk;

	omni_wheel_move_controller DUT (.*);

	omni_wheel_move_controller_checker checker_i (.*);

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel) idle <= 0;
		else idle <= idle + 1;
		if (idle >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stalls: random length bursts, with stall-free stretches
	always @(posedge clk) begin
		int n;
		if (arst_n) begin
			if ($urandom_range(0, 3) == 0) n = 0;
			else n = $urandom_range(0, 7);
			if (n != 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(input cmd_t c, input bit gaps);
		int g;
		g = gaps ? $urandom_range(0, 7) : 0;
		if (g != 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic drain;
		cmd_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] vel;
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// encoder counts mostly near the travel target so drive and stop both occur
	function automatic logic [31:0] enc;
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3: return $urandom;
			default: begin
				v = $urandom_range(0, 1 << ($urandom_range(0, 24)));
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	function automatic cmd_t rand_cmd;
		cmd_t c;
		c.vel_x = vel();
		c.vel_y = vel();
		c.rot_w = vel();
		c.enc_count_1 = enc();
		c.enc_count_2 = enc();
		c.enc_count_3 = enc();
		return c;
	endfunction

	initial begin
		cmd_t c;
		logic [31:0] scales[5] = '{32'd1, 32'd255, 32'd0, 32'd17, 32'd3};
		logic [31:0] tols[5] = '{32'h0000, 32'h7fff, 32'h8000, 32'hffff, 32'h0040};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero command, extremes, negative velocities, most negative count
		send('0, 0);
		c = '0;
		c.vel_x = 16'h7fff;
		send(c, 0);
		c.vel_x = 16'h8000;
		send(c, 0);
		c = '0;
		c.vel_y = 16'h8000;
		send(c, 0);
		c.vel_y = 16'h7fff;
		send(c, 0);
		c = '0;
		c.rot_w = 16'h7fff;
		send(c, 0);
		c.rot_w = 16'h8000;
		c.enc_count_1 = 32'h80000000;
		c.enc_count_2 = 32'h7fffffff;
		c.enc_count_3 = 32'hffffffff;
		send(c, 0);
		c = '{16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h0, 32'h7fffffff};
		send(c, 0);
		c = '{16'h7fff, 16'h7fff, 16'h7fff, 32'h1, 32'h2, 32'h3};
		send(c, 0);
		c = '{16'h0001, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0};
		send(c, 0);
		for (int p = 0; p < 5; p++) begin
			drain();
			reg_write(ADDR_W'(0), scales[p]);
			reg_write(ADDR_W'(4), tols[p]);
			for (int i = 0; i < 160; i++) send(rand_cmd(), $urandom_range(0, 3) != 0);
		end
		cmd_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/owmc_pkg.sv
rtl/owmc_kin.sv
rtl/owmc_div.sv
rtl/owmc_tgt.sv
rtl/omni_wheel_move_controller.sv
dv/omni_wheel_move_controller_checker.sv
dv/omni_wheel_move_controller_test.sv
